>>> hw/rtl/alc_pkg.sv
// ---------------------------------------------------------------------------
// alc_pkg: shared types and constants for the light cosine core
// Widths of the vector fields, products, root and quotient, plus the
// per-stage records that travel down the root and divider pipelines.
// ---------------------------------------------------------------------------
`default_nettype none
package alc_pkg;
    localparam int FIELD_W = 31;
    localparam int PROD_W  = 62;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int MAG_W   = 63;
    localparam int COS_W   = 32;

    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } root_stage_t;

    typedef struct packed {
        logic [ROOT_W:0]   rem;
        logic [MAG_W-1:0]  quo;
        logic [ROOT_W-1:0] den;
        logic              neg;
        logic              zero;
    } div_stage_t;
endpackage
`default_nettype wire

>>> hw/rtl/alc_mac.sv
// ---------------------------------------------------------------------------
// alc_mac: squared length and dot product
// Stage 1 registers six 31x31 products, stage 2 registers the two sums.
// ---------------------------------------------------------------------------
`default_nettype none
module alc_mac (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic signed [alc_pkg::FIELD_W-1:0] ax, ay, az, lx, ly, lz,
    output logic                                 out_valid,
    output logic [alc_pkg::SUM_W-1:0]            len2,
    output logic signed [alc_pkg::SUM_W-1:0]     dot
);
    localparam int SUM_W = alc_pkg::SUM_W;
    logic signed [alc_pkg::PROD_W-1:0] p_reg [6];
    logic v1_reg, v2_reg;
    logic [alc_pkg::SUM_W-1:0] len2_reg;
    logic signed [alc_pkg::SUM_W-1:0] dot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        if (en) begin
            p_reg[0] <= ax * ax;
            p_reg[1] <= ay * ay;
            p_reg[2] <= az * az;
            p_reg[3] <= ax * lx;
            p_reg[4] <= ay * ly;
            p_reg[5] <= az * lz;
            len2_reg <= unsigned'(SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]) + SUM_W'(p_reg[2]));
            dot_reg  <= SUM_W'(p_reg[3]) + SUM_W'(p_reg[4]) + SUM_W'(p_reg[5]);
        end
    end

    assign out_valid = v2_reg;
    assign len2      = len2_reg;
    assign dot       = dot_reg;
endmodule
`default_nettype wire

>>> hw/rtl/alc_root.sv
// ---------------------------------------------------------------------------
// alc_root: pipelined floor square root
// One result bit per stage, 32 stages; the dot magnitude rides along.
// ---------------------------------------------------------------------------
`default_nettype none
module alc_root (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [alc_pkg::SUM_W-1:0]     len2,
    input  wire logic signed [alc_pkg::SUM_W-1:0] dot,
    output logic                               out_valid,
    output alc_pkg::root_stage_t               out_stage
);
    localparam int N = alc_pkg::ROOT_W;
    alc_pkg::root_stage_t st_reg [N+1];
    logic [N:0] v_reg;
    alc_pkg::root_stage_t st0;

    always_comb begin
        st0.rem  = len2;
        st0.root = '0;
        st0.neg  = dot[alc_pkg::SUM_W-1];
        st0.mag  = alc_pkg::MAG_W'(dot[alc_pkg::SUM_W-1] ? -dot : dot);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (en) v_reg <= {v_reg[N-1:0], in_valid};
        if (en) st_reg[0] <= st0;
    end

    // restoring root: trial = (root<<2|1) against the top remainder pair
    for (genvar i = 0; i < N; i++) begin : g_st
        logic [N+1:0] trial;
        logic [N+1:0] top;
        alc_pkg::root_stage_t nx;
        always_comb begin
            nx    = st_reg[i];
            top   = (N+2)'(st_reg[i].rem >> (2*(N-1-i)));
            trial = {st_reg[i].root, 2'b01};
            nx.root = {st_reg[i].root[N-2:0], 1'b0};
            if (top >= trial) begin
                nx.rem  = st_reg[i].rem - (alc_pkg::SUM_W'(trial) << (2*(N-1-i)));
                nx.root[0] = 1'b1;
            end
        end
        always_ff @(posedge aclk) if (en) st_reg[i+1] <= nx;
    end

    assign out_valid = v_reg[N];
    assign out_stage = st_reg[N];
endmodule
`default_nettype wire

>>> hw/rtl/alc_div.sv
// ---------------------------------------------------------------------------
// alc_div: pipelined restoring divider with sign fix and saturation
// 63 quotient bits, one per stage, then a saturating output stage.
// ---------------------------------------------------------------------------
`default_nettype none
module alc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire alc_pkg::root_stage_t          in_stage,
    output logic                               out_valid,
    output logic [alc_pkg::COS_W-1:0]          cosine,
    output logic                               zero_length
);
    localparam int M = alc_pkg::MAG_W;
    localparam int R = alc_pkg::ROOT_W;
    alc_pkg::div_stage_t st_reg [M+1];
    logic [M:0] v_reg;
    alc_pkg::div_stage_t st0;
    logic [R-1:0] cos_reg;
    logic zl_reg, vo_reg;
    logic [M:0] sq;

    always_comb begin
        st0.rem  = '0;
        st0.quo  = in_stage.mag;
        st0.den  = in_stage.root;
        st0.neg  = in_stage.neg;
        st0.zero = (in_stage.root == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[M-1:0], in_valid};
            vo_reg <= v_reg[M];
        end
        if (en) st_reg[0] <= st0;
    end

    // quotient bits shift in where dividend bits shift out
    for (genvar i = 0; i < M; i++) begin : g_st
        alc_pkg::div_stage_t nx;
        logic [R+1:0] sh;
        always_comb begin
            nx  = st_reg[i];
            sh  = {st_reg[i].rem, st_reg[i].quo[M-1]};
            nx.quo = {st_reg[i].quo[M-2:0], 1'b0};
            if (sh >= {2'b00, st_reg[i].den}) begin
                nx.rem = (R+1)'(sh - {2'b00, st_reg[i].den});
                nx.quo[0] = 1'b1;
            end else begin
                nx.rem = (R+1)'(sh);
            end
        end
        always_ff @(posedge aclk) if (en) st_reg[i+1] <= nx;
    end

    always_comb sq = st_reg[M].neg ? -{1'b0, st_reg[M].quo} : {1'b0, st_reg[M].quo};

    always_ff @(posedge aclk) begin
        if (en) begin
            zl_reg <= st_reg[M].zero;
            if (st_reg[M].zero) cos_reg <= '0;
            else if (!st_reg[M].neg && st_reg[M].quo > M'(32'h7fff_ffff))
                cos_reg <= 32'h7fff_ffff;
            else if (st_reg[M].neg && st_reg[M].quo > M'(33'h0_8000_0000))
                cos_reg <= 32'h8000_0000;
            else cos_reg <= sq[R-1:0];
        end
    end

    assign out_valid   = vo_reg;
    assign cosine      = cos_reg;
    assign zero_length = zl_reg;
endmodule
`default_nettype wire

>>> hw/rtl/axis_light_cosine_core.sv
// ---------------------------------------------------------------------------
// axis_light_cosine_core: normalized dot product of axis and light vectors
// Exact squared length, floor root, truncating divide, signed saturation.
// ---------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                      | tuser
//  s_axis  | in  | col_x col_y col_z light_x light_y light_z (186b) | -
//  m_axis  | out | cosine (32b)                                    | zero_length
//
//  Pipeline stages: 2 MAC, 33 root, 64 divider, 1 saturate.
//  One word accepted per cycle unless the output stalls; root and divider set depth.
//  The whole pipeline advances when the output register is empty or taken.
//  Reset clears valid bits only.
// ---------------------------------------------------------------------------
`default_nettype none
module axis_light_cosine_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [191:0] s_axis_tdata,  // col_x,col_y,col_z,light_x,light_y,light_z
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [31:0]       m_axis_tdata,  // cosine
    output logic              m_axis_tuser   // zero_length
);
    localparam int W = alc_pkg::FIELD_W;
    logic en, mv, rv;
    logic [alc_pkg::SUM_W-1:0] len2;
    logic signed [alc_pkg::SUM_W-1:0] dot;
    alc_pkg::root_stage_t rs;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    alc_mac u_mac (
        .aclk, .aresetn, .en, .in_valid(s_axis_tvalid),
        .ax(s_axis_tdata[W-1:0]),     .ay(s_axis_tdata[2*W-1:W]),
        .az(s_axis_tdata[3*W-1:2*W]), .lx(s_axis_tdata[4*W-1:3*W]),
        .ly(s_axis_tdata[5*W-1:4*W]), .lz(s_axis_tdata[6*W-1:5*W]),
        .out_valid(mv), .len2, .dot
    );

    alc_root u_root (
        .aclk, .aresetn, .en, .in_valid(mv), .len2, .dot,
        .out_valid(rv), .out_stage(rs)
    );

    alc_div u_div (
        .aclk, .aresetn, .en, .in_valid(rv), .in_stage(rs),
        .out_valid(m_axis_tvalid), .cosine(m_axis_tdata), .zero_length(m_axis_tuser)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero length with nonzero cosine");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule
`default_nettype wire
